// ----- rtl/rfrv_pkg.sv -----
// constants and pointer helpers for the ring fifo with remove by value
// no dependencies; used by the top level
package rfrv_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 4;

  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
  localparam logic [OP_W-1:0] OP_ENQ       = 3'd1;
  localparam logic [OP_W-1:0] OP_DEQ       = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK_HEAD = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_TAIL = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] wrap_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST_SLOT : p - 1'b1;
  endfunction

  // entries between head and tail, modulo the ring size
  function automatic logic [PTR_W-1:0] held(input logic [PTR_W-1:0] h,
                                             input logic [PTR_W-1:0] t);
    logic [PTR_W:0] d;
    d = {1'b0, t} - {1'b0, h};
    if (t < h) begin
      d = d + (PTR_W + 1)'(DEPTH);
    end
    return d[PTR_W-1:0];
  endfunction

endpackage

// ----- rtl/rfrv_ram.sv -----
// generic simple dual-port ram: one write port, one read port
// read data registered; no dependencies
module rfrv_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 4,
  parameter int WORDS  = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ring_fifo_with_remove_by_value_top.sv -----
// ring fifo of signed words with clear, enqueue, dequeue, peeks and remove by value
// uses rfrv_pkg and the slot memory rfrv_ram
//
// Each request gives exactly one result. Clear, enqueue, dequeue and the peeks are
// taken one per cycle while the output is not stalled. Accepting a request does the
// slot memory access and loads the pending result, which then moves into the output
// register once that register is free or its result is being taken. So a result waits
// in the pending result register while an earlier result is still on the output.
// Remove by value walks the queue from the head through the single read port of the
// slot memory: it holds in_ready low while it examines the entries up to the match
// (or all entries if none matches) and while it moves each later entry one place
// toward the head. The slots need no initialization pass after reset; only entries
// between head and tail are ever read.
module ring_fifo_with_remove_by_value_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rfrv_pkg::OP_W-1:0]           op,
  input  logic signed [rfrv_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rfrv_pkg::ST_W-1:0]           status,
  output logic signed [rfrv_pkg::DATA_W-1:0]  data,
  output logic [rfrv_pkg::CNT_W-1:0]          count,
  output logic                                is_empty_flag,
  output logic                                is_full_flag
);

  typedef enum logic [1:0] {S_IDLE, S_SRCH, S_SHIFT} state_t;

  typedef struct packed {
    logic [rfrv_pkg::ST_W-1:0]   status;
    logic [rfrv_pkg::DATA_W-1:0] data;
    logic [rfrv_pkg::CNT_W-1:0]  count;
    logic                        empty;
    logic                        full;
    logic                        use_q;
  } res_t;

  state_t                       state, state_next;
  logic [rfrv_pkg::PTR_W-1:0]   head, head_next;
  logic [rfrv_pkg::PTR_W-1:0]   tail, tail_next;
  logic [rfrv_pkg::PTR_W-1:0]   walk, walk_next;
  logic [rfrv_pkg::DATA_W-1:0]  vreg, vreg_next;
  res_t                         pv, pv_next;
  logic                         pv_valid, pv_valid_next;

  logic                         ram_we, ram_re;
  logic [rfrv_pkg::PTR_W-1:0]   ram_waddr, ram_raddr;
  logic [rfrv_pkg::DATA_W-1:0]  ram_wdata, ram_q;

  logic                         advance, load_pv;
  logic [rfrv_pkg::ST_W-1:0]    res_status;
  logic [rfrv_pkg::DATA_W-1:0]  res_data;
  logic                         res_use_q;
  logic [rfrv_pkg::PTR_W-1:0]   n_now, n_after, nxt;

  rfrv_ram #(
    .DATA_W (rfrv_pkg::DATA_W),
    .ADDR_W (rfrv_pkg::PTR_W),
    .WORDS  (rfrv_pkg::DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // pending result may move on when the output register is free or leaving
  assign advance  = !pv_valid || !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && advance;
  assign n_now    = rfrv_pkg::held(head, tail);
  assign nxt      = rfrv_pkg::wrap_next(walk);

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    walk_next     = walk;
    vreg_next     = vreg;
    pv_valid_next = pv_valid;
    ram_we        = 1'b0;
    ram_waddr     = tail;
    ram_wdata     = value;
    ram_re        = 1'b0;
    ram_raddr     = head;
    load_pv       = 1'b0;
    res_status    = rfrv_pkg::ST_OK;
    res_data      = '0;
    res_use_q     = 1'b0;

    if (advance && pv_valid) begin
      pv_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          load_pv = 1'b1;
          case (op)
            rfrv_pkg::OP_CLEAR: begin
              head_next = '0;
              tail_next = '0;
            end
            rfrv_pkg::OP_ENQ: begin
              if (n_now == rfrv_pkg::LAST_SLOT) begin
                res_status = rfrv_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                tail_next = rfrv_pkg::wrap_next(tail);
              end
            end
            rfrv_pkg::OP_DEQ: begin
              if (n_now == '0) begin
                res_status = rfrv_pkg::ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                res_use_q = 1'b1;
                head_next = rfrv_pkg::wrap_next(head);
              end
            end
            rfrv_pkg::OP_PEEK_HEAD: begin
              if (n_now == '0) begin
                res_status = rfrv_pkg::ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                res_use_q = 1'b1;
              end
            end
            rfrv_pkg::OP_PEEK_TAIL: begin
              if (n_now == '0) begin
                res_status = rfrv_pkg::ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = rfrv_pkg::wrap_prev(tail);
                res_use_q = 1'b1;
              end
            end
            rfrv_pkg::OP_REMOVE: begin
              if (n_now == '0) begin
                res_status = rfrv_pkg::ST_EMPTY;
              end else begin
                // start the search at the head, result comes when the walk ends
                load_pv    = 1'b0;
                ram_re     = 1'b1;
                walk_next  = head;
                vreg_next  = value;
                state_next = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SRCH: begin
        // ram_q holds the slot at walk
        if (ram_q == vreg) begin
          if (nxt == tail) begin
            tail_next  = rfrv_pkg::wrap_prev(tail);
            load_pv    = 1'b1;
            res_data   = vreg;
            state_next = S_IDLE;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = nxt;
            state_next = S_SHIFT;
          end
        end else if (nxt == tail) begin
          load_pv    = 1'b1;
          res_status = rfrv_pkg::ST_EMPTY;
          state_next = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = nxt;
          walk_next = nxt;
        end
      end
      S_SHIFT: begin
        // ram_q holds the slot after walk; move it down one place
        ram_we    = 1'b1;
        ram_waddr = walk;
        ram_wdata = ram_q;
        if (rfrv_pkg::wrap_next(nxt) == tail) begin
          tail_next  = rfrv_pkg::wrap_prev(tail);
          load_pv    = 1'b1;
          res_data   = vreg;
          state_next = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = rfrv_pkg::wrap_next(nxt);
          walk_next = nxt;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    n_after = rfrv_pkg::held(head_next, tail_next);
    pv_next = pv;
    if (load_pv) begin
      pv_valid_next  = 1'b1;
      pv_next.status = res_status;
      pv_next.data   = res_data;
      pv_next.use_q  = res_use_q;
      pv_next.count  = rfrv_pkg::CNT_W'(n_after);
      pv_next.empty  = (n_after == '0);
      pv_next.full   = (n_after == rfrv_pkg::LAST_SLOT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      pv_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      pv_valid <= pv_valid_next;
      if (advance && pv_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    walk <= walk_next;
    vreg <= vreg_next;
    pv   <= pv_next;
    if (advance && pv_valid) begin
      status        <= pv.status;
      data          <= pv.use_q ? ram_q : pv.data;
      count         <= pv.count;
      is_empty_flag <= pv.empty;
      is_full_flag  <= pv.full;
    end
  end

  a_walk_no_pending: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !pv_valid)
    else $error("pending result during remove walk");

  a_hold_read_data: assert property (@(posedge clk) disable iff (rst)
    pv_valid && pv.use_q && out_valid && !out_ready |-> !ram_re)
    else $error("slot read while a read result waits");

  a_no_same_slot: assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("read and write of the same slot in one cycle");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    pv_valid && pv.status == rfrv_pkg::ST_FULL |-> pv.full)
    else $error("full status without full flag");

endmodule
